@@ rtl/rbd_pkg.sv @@
// Shared constants, payload types and helper functions of the backward differentiator.
package rbd_pkg;

   // Sizes of the per-joint history.
   localparam int JOINT_COUNT   = 8;
   localparam int MAX_LONG_STEP = 8;
   localparam int RING_DEPTH    = 2 * MAX_LONG_STEP + 1;
   localparam int SLOT_W        = $clog2(RING_DEPTH);
   localparam int COUNT_W       = $clog2(RING_DEPTH + 1);
   localparam int HIST_DEPTH    = JOINT_COUNT * RING_DEPTH;
   localparam int HIST_ADDR_W   = $clog2(HIST_DEPTH);
   localparam int STEP_W        = 4;
   localparam int JOINT_W       = 3;

   // Datapath widths.
   localparam int DATA_W     = 32;
   localparam int DIFF_W     = 38;
   localparam int MUL_A_W    = 38;
   localparam int MUL_B_W    = 32;
   localparam int MUL_PART_W = 19;
   localparam int MUL_PP_W   = MUL_PART_W + MUL_B_W;
   localparam int MUL_PROD_W = MUL_A_W + MUL_B_W;
   localparam int FINAL_W    = 54;

   // Register indexes of the configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_SAMPLING_TIME = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_STEP_SCALE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_POSITION  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_WEIGHT       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_WEIGHT      = 3'd4;

   // Reset values of the configuration registers.
   localparam logic [DATA_W-1:0]        INV_SAMPLING_TIME_RST = 32'd65536000;
   localparam logic [STEP_W-1:0]        LONG_STEP_SCALE_RST   = 4'd2;
   localparam logic signed [DATA_W-1:0] INITIAL_POSITION_RST  = 32'sd0;
   localparam logic signed [DATA_W-1:0] LONG_WEIGHT_RST       = -32'sd89478485;
   localparam logic signed [DATA_W-1:0] SHORT_WEIGHT_RST      = -32'sd715827883;

   // Method codes reported with each estimate.
   localparam logic [1:0] METHOD_INITIAL    = 2'd0;
   localparam logic [1:0] METHOD_EULER      = 2'd1;
   localparam logic [1:0] METHOD_RICHARDSON = 2'd2;

   typedef struct packed {
      logic [JOINT_W-1:0]        joint;
      logic signed [DATA_W-1:0]  position;
   } req_type;

   typedef struct packed {
      logic [JOINT_W-1:0]        joint_out;
      logic signed [DATA_W-1:0]  velocity;
      logic [1:0]                method;
      logic                      clipped;
   } rsp_type;

   typedef struct packed {
      logic                      wr_en;
      logic [HIST_ADDR_W-1:0]    wr_addr;
      logic signed [DATA_W-1:0]  wr_data;
      logic [HIST_ADDR_W-1:0]    rd_addr_a;
      logic [HIST_ADDR_W-1:0]    rd_addr_b;
   } hist_req_type;

   typedef struct packed {
      logic                      start;
      logic [MUL_A_W-1:0]        a;
      logic [MUL_B_W-1:0]        b;
   } mul_req_type;

   // Flat history address of one slot of one joint's ring.
   function automatic logic [HIST_ADDR_W-1:0] hist_addr(input logic [JOINT_W-1:0] joint,
                                                        input logic [SLOT_W-1:0] slot);
      return HIST_ADDR_W'(joint) * HIST_ADDR_W'(RING_DEPTH) + HIST_ADDR_W'(slot);
   endfunction

   // Ring slot that lies a given number of samples behind the newest one.
   function automatic logic [SLOT_W-1:0] back_slot(input logic [SLOT_W-1:0] slot,
                                                   input logic [SLOT_W-1:0] back);
      logic [SLOT_W:0] sum;
      sum = {1'b0, slot} + (SLOT_W+1)'(RING_DEPTH) - {1'b0, back};
      if (sum >= (SLOT_W+1)'(RING_DEPTH)) begin
         sum = sum - (SLOT_W+1)'(RING_DEPTH);
      end
      return sum[SLOT_W-1:0];
   endfunction

endpackage

@@ rtl/rbd_history_ram.sv @@
// History memory of all joints' position rings, one write and two registered reads a cycle.
module rbd_history_ram (
   input  logic                              clock,
   input  rbd_pkg::hist_req_type             hist_req,
   output logic signed [rbd_pkg::DATA_W-1:0] rd_data_a,
   output logic signed [rbd_pkg::DATA_W-1:0] rd_data_b
);
   import rbd_pkg::*;

   logic signed [DATA_W-1:0] hist_mem [HIST_DEPTH];
   logic signed [DATA_W-1:0] rd_a_ff;
   logic signed [DATA_W-1:0] rd_b_ff;

   // Write the newest sample and read two older ones.
   always_ff @(posedge clock) begin
      if (hist_req.wr_en) begin
         hist_mem[hist_req.wr_addr] <= hist_req.wr_data;
      end
      rd_a_ff <= hist_mem[hist_req.rd_addr_a];
      rd_b_ff <= hist_mem[hist_req.rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ rtl/rbd_mul.sv @@
// Shared unsigned multiplier that forms a 38 by 32 bit product from two partial products.
module rbd_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  rbd_pkg::mul_req_type              mul_req,
   output logic                              done,
   output logic [rbd_pkg::MUL_PROD_W-1:0]    product
);
   import rbd_pkg::*;

   typedef enum logic [1:0] {
      MUL_LOW,
      MUL_HIGH,
      MUL_ACC
   } step_type;

   step_type                step_ff;
   logic                    busy_ff;
   logic                    done_ff;
   logic [MUL_A_W-1:0]      a_ff;
   logic [MUL_B_W-1:0]      b_ff;
   logic [MUL_PP_W-1:0]     pp_ff;
   logic [MUL_PROD_W-1:0]   acc_ff;
   logic [MUL_PART_W-1:0]   a_part;
   logic [MUL_PP_W-1:0]     pp_in;

   // One partial product per cycle: the low slice of a first, then the high slice.
   assign a_part = (step_ff == MUL_LOW) ? a_ff[MUL_PART_W-1:0] : a_ff[MUL_A_W-1:MUL_PART_W];
   assign pp_in  = MUL_PP_W'(a_part) * MUL_PP_W'(b_ff);

   // Low half product, then high half product, then shifted accumulate.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= MUL_LOW;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (mul_req.start) begin
            a_ff    <= mul_req.a;
            b_ff    <= mul_req.b;
            step_ff <= MUL_LOW;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            case (step_ff)
               MUL_LOW: begin
                  pp_ff   <= pp_in;
                  step_ff <= MUL_HIGH;
               end
               MUL_HIGH: begin
                  acc_ff  <= MUL_PROD_W'(pp_ff);
                  pp_ff   <= pp_in;
                  step_ff <= MUL_ACC;
               end
               MUL_ACC: begin
                  acc_ff  <= acc_ff + (MUL_PROD_W'(pp_ff) << MUL_PART_W);
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
                  step_ff <= MUL_LOW;
               end
               default: begin
                  busy_ff <= 1'b0;
                  step_ff <= MUL_LOW;
               end
            endcase
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

@@ rtl/richardson_backward_differentiator_top.sv @@
// Top level: sequencer, difference datapath, configuration registers and output register.
// Each accepted beat runs through the history reads, the difference step and passes through
// the shared multiplier: one pass for the initial-value and Euler methods, three passes in
// turn for Richardson. The block takes no new beat until the result of the last one is
// loaded into the output register, which can hold back on rsp_ready.
// Reset is synchronous and active high; it clears sample counts, ring pointers and the
// configuration registers to their defaults; history contents stay undefined until written.
module richardson_backward_differentiator_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  rbd_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output rbd_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [rbd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [rbd_pkg::DATA_W-1:0]           csr_wdata
);
   import rbd_pkg::*;

   localparam int WEIGHT_SHIFT = 30;
   localparam int TIME_SHIFT   = 16;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ_SHORT,
      ST_READ_LONG,
      ST_DIFF,
      ST_MUL_START,
      ST_MUL_WAIT,
      ST_COMBINE,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      OP_LONG,
      OP_SHORT,
      OP_FINAL
   } op_type;

   // Configuration registers.
   logic [DATA_W-1:0]         inv_time_ff;
   logic [STEP_W-1:0]         long_step_ff;
   logic signed [DATA_W-1:0]  init_pos_ff;
   logic signed [DATA_W-1:0]  long_weight_ff;
   logic signed [DATA_W-1:0]  short_weight_ff;

   // Per-joint counts and ring pointers.
   logic [COUNT_W-1:0]        count_ff [JOINT_COUNT];
   logic [SLOT_W-1:0]         ptr_ff [JOINT_COUNT];

   // Sequencer and working registers.
   state_type                 state_ff;
   op_type                    op_ff;
   logic [JOINT_W-1:0]        joint_ff;
   logic signed [DATA_W-1:0]  x_ff;
   logic [SLOT_W-1:0]         slot_ff;
   logic [STEP_W-1:0]         h_ff;
   logic [1:0]                method_ff;
   logic signed [DATA_W-1:0]  y1_ff;
   logic signed [DATA_W-1:0]  y2_ff;
   logic signed [DIFF_W-1:0]  d1_ff;
   logic signed [DIFF_W-1:0]  dh_ff;
   logic signed [DIFF_W-1:0]  p2_ff;
   logic signed [DIFF_W-1:0]  p1_ff;
   logic signed [DIFF_W-1:0]  diff_ff;
   logic [FINAL_W-1:0]        mag_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;

   hist_req_type              hist_req;
   logic signed [DATA_W-1:0]  rd_data_a;
   logic signed [DATA_W-1:0]  rd_data_b;
   mul_req_type               mul_req;
   logic                      mul_done;
   logic [MUL_PROD_W-1:0]     mul_product;

   logic                      req_accept;
   logic [COUNT_W-1:0]        count_cur;
   logic [COUNT_W-1:0]        count_in;
   logic [SLOT_W-1:0]         slot_cur;
   logic [SLOT_W-1:0]         ptr_in;
   logic [STEP_W-1:0]         h_clamp;
   logic [SLOT_W-1:0]         two_h_acc;
   logic [SLOT_W-1:0]         two_h_held;
   logic [1:0]                method_in;
   logic signed [DIFF_W-1:0]  x_ext;
   logic [DIFF_W-1:0]         long_mag;
   logic [DIFF_W-1:0]         short_mag;
   logic [DIFF_W-1:0]         diff_mag;
   logic [MUL_B_W-1:0]        long_w_mag;
   logic [MUL_B_W-1:0]        short_w_mag;
   logic [DIFF_W-1:0]         weight_round;
   logic [FINAL_W-1:0]        time_round;
   logic [MUL_PROD_W-1:0]     weight_sum;
   logic [MUL_PROD_W-1:0]     time_sum;
   logic                      out_free;
   logic                      final_neg;
   logic                      final_clip;
   logic signed [DATA_W-1:0]  final_vel;

   // Magnitude of a signed difference.
   function automatic logic [DIFF_W-1:0] mag_diff(input logic signed [DIFF_W-1:0] v);
      return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
   endfunction

   // Magnitude of a signed 32 bit register.
   function automatic logic [MUL_B_W-1:0] mag_word(input logic signed [DATA_W-1:0] v);
      return v[DATA_W-1] ? MUL_B_W'(-v) : MUL_B_W'(v);
   endfunction

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // Configuration write port.
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_time_ff     <= INV_SAMPLING_TIME_RST;
         long_step_ff    <= LONG_STEP_SCALE_RST;
         init_pos_ff     <= INITIAL_POSITION_RST;
         long_weight_ff  <= LONG_WEIGHT_RST;
         short_weight_ff <= SHORT_WEIGHT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_INV_SAMPLING_TIME: inv_time_ff     <= csr_wdata;
            CSR_LONG_STEP_SCALE:   long_step_ff    <= csr_wdata[STEP_W-1:0];
            CSR_INITIAL_POSITION:  init_pos_ff     <= csr_wdata;
            CSR_LONG_WEIGHT:       long_weight_ff  <= csr_wdata;
            CSR_SHORT_WEIGHT:      short_weight_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Beat admission: clamp the long step, advance the count and ring pointer, pick the method.
   always_comb begin
      count_cur = count_ff[req_data.joint];
      slot_cur  = ptr_ff[req_data.joint];
      if (count_cur < COUNT_W'(RING_DEPTH)) begin
         count_in = count_cur + COUNT_W'(1);
      end else begin
         count_in = count_cur;
      end
      if (slot_cur == SLOT_W'(RING_DEPTH - 1)) begin
         ptr_in = '0;
      end else begin
         ptr_in = slot_cur + SLOT_W'(1);
      end
      if (long_step_ff == '0) begin
         h_clamp = STEP_W'(1);
      end else if (long_step_ff > STEP_W'(MAX_LONG_STEP)) begin
         h_clamp = STEP_W'(MAX_LONG_STEP);
      end else begin
         h_clamp = long_step_ff;
      end
      two_h_acc = SLOT_W'({h_clamp, 1'b0});
      if (count_in <= COUNT_W'(1)) begin
         method_in = METHOD_INITIAL;
      end else if (COUNT_W'(count_in) > COUNT_W'(two_h_acc)) begin
         method_in = METHOD_RICHARDSON;
      end else begin
         method_in = METHOD_EULER;
      end
   end

   assign two_h_held = SLOT_W'({h_ff, 1'b0});

   // History writes on admission, reads of older samples in the two read states.
   always_comb begin
      hist_req.wr_en   = req_accept;
      hist_req.wr_addr = hist_addr(req_data.joint, slot_cur);
      hist_req.wr_data = req_data.position;
      if (state_ff == ST_READ_SHORT) begin
         hist_req.rd_addr_a = hist_addr(joint_ff, back_slot(slot_ff, SLOT_W'(1)));
         hist_req.rd_addr_b = hist_addr(joint_ff, back_slot(slot_ff, SLOT_W'(2)));
      end else begin
         hist_req.rd_addr_a = hist_addr(joint_ff, back_slot(slot_ff, SLOT_W'(h_ff)));
         hist_req.rd_addr_b = hist_addr(joint_ff, back_slot(slot_ff, two_h_held));
      end
   end

   rbd_history_ram u_history (
      .clock     (clock),
      .hist_req  (hist_req),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Operand selection for the shared multiplier.
   always_comb begin
      long_mag    = mag_diff(dh_ff);
      short_mag   = mag_diff(d1_ff);
      diff_mag    = mag_diff(diff_ff);
      long_w_mag  = mag_word(long_weight_ff);
      short_w_mag = mag_word(short_weight_ff);
      mul_req.start = (state_ff == ST_MUL_START);
      case (op_ff)
         OP_LONG: begin
            mul_req.a = MUL_A_W'(long_mag);
            mul_req.b = long_w_mag;
         end
         OP_SHORT: begin
            mul_req.a = MUL_A_W'(short_mag);
            mul_req.b = short_w_mag;
         end
         default: begin
            mul_req.a = MUL_A_W'(diff_mag);
            mul_req.b = inv_time_ff;
         end
      endcase
   end

   rbd_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .done    (mul_done),
      .product (mul_product)
   );

   // Rounding of products, half away from zero on the magnitude.
   always_comb begin
      weight_sum   = mul_product + (MUL_PROD_W'(1) << (WEIGHT_SHIFT - 1));
      time_sum     = mul_product + (MUL_PROD_W'(1) << (TIME_SHIFT - 1));
      weight_round = weight_sum[WEIGHT_SHIFT +: DIFF_W];
      time_round   = time_sum[TIME_SHIFT +: FINAL_W];
      x_ext        = DIFF_W'(x_ff);
   end

   // Saturation of the final magnitude to signed 32 bits.
   always_comb begin
      final_neg = diff_ff[DIFF_W-1];
      if (final_neg) begin
         final_clip = (mag_ff > FINAL_W'(64'h8000_0000));
      end else begin
         final_clip = (mag_ff > FINAL_W'(64'h7FFF_FFFF));
      end
      if (final_clip) begin
         final_vel = final_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else if (final_neg) begin
         final_vel = DATA_W'(-mag_ff[DATA_W-1:0]);
      end else begin
         final_vel = DATA_W'(mag_ff[DATA_W-1:0]);
      end
   end

   // Sequencer with its working registers, joint tables and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_LONG;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < JOINT_COUNT; i++) begin
            count_ff[i] <= '0;
            ptr_ff[i]   <= '0;
         end
      end else begin
         // A taken beat leaves unless the done state puts a new one in its place.
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  joint_ff                 <= req_data.joint;
                  x_ff                     <= req_data.position;
                  slot_ff                  <= slot_cur;
                  h_ff                     <= h_clamp;
                  method_ff                <= method_in;
                  count_ff[req_data.joint] <= count_in;
                  ptr_ff[req_data.joint]   <= ptr_in;
                  state_ff                 <= ST_READ_SHORT;
               end
            end
            ST_READ_SHORT: begin
               state_ff <= ST_READ_LONG;
            end
            ST_READ_LONG: begin
               y1_ff    <= rd_data_a;
               y2_ff    <= rd_data_b;
               state_ff <= ST_DIFF;
            end
            ST_DIFF: begin
               // Second-order differences 3x - 4y + z at the unit and long steps.
               d1_ff <= (x_ext <<< 1) + x_ext - (DIFF_W'(y1_ff) <<< 2) + DIFF_W'(y2_ff);
               dh_ff <= (x_ext <<< 1) + x_ext - (DIFF_W'(rd_data_a) <<< 2)
                        + DIFF_W'(rd_data_b);
               if (method_ff == METHOD_INITIAL) begin
                  diff_ff <= x_ext - DIFF_W'(init_pos_ff);
                  op_ff   <= OP_FINAL;
               end else if (method_ff == METHOD_EULER) begin
                  diff_ff <= x_ext - DIFF_W'(y1_ff);
                  op_ff   <= OP_FINAL;
               end else begin
                  op_ff   <= OP_LONG;
               end
               state_ff <= ST_MUL_START;
            end
            ST_MUL_START: begin
               state_ff <= ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
               if (mul_done) begin
                  case (op_ff)
                     OP_LONG: begin
                        if (dh_ff[DIFF_W-1] ^ long_weight_ff[DATA_W-1]) begin
                           p2_ff <= -$signed(weight_round);
                        end else begin
                           p2_ff <= $signed(weight_round);
                        end
                        op_ff    <= OP_SHORT;
                        state_ff <= ST_MUL_START;
                     end
                     OP_SHORT: begin
                        if (d1_ff[DIFF_W-1] ^ short_weight_ff[DATA_W-1]) begin
                           p1_ff <= -$signed(weight_round);
                        end else begin
                           p1_ff <= $signed(weight_round);
                        end
                        state_ff <= ST_COMBINE;
                     end
                     default: begin
                        mag_ff   <= time_round;
                        state_ff <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_COMBINE: begin
               diff_ff  <= p2_ff - p1_ff;
               op_ff    <= OP_FINAL;
               state_ff <= ST_MUL_START;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_ff.joint_out <= joint_ff;
                  rsp_ff.velocity  <= final_vel;
                  rsp_ff.method    <= method_ff;
                  rsp_ff.clipped   <= final_clip;
                  rsp_valid_ff     <= 1'b1;
                  state_ff         <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
